/* sv/assert_macros.svh */
// assertion macros for the rtl file that checks itself (key_debounce_auto_repeat)
// expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/kbar_pkg.sv */
// types, constants and codes for the key debounce / auto-repeat block
// no dependencies
`default_nettype none

package kbar_pkg;

    localparam int NUM_KEYS   = 10;
    localparam int KEY_W      = $clog2(NUM_KEYS);
    localparam int MASK_W     = 10;
    localparam int TIME_W     = 32;
    localparam int HOLD_W     = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST  = PERIOD_W'(10);
    localparam logic [HOLD_W-1:0]   FIRST_REPEAT_RST = HOLD_W'(500);
    localparam logic [HOLD_W-1:0]   REPEAT_RST       = HOLD_W'(100);
    localparam logic [MASK_W-1:0]   KEY_ENABLE_RST   = MASK_W'(238);
    localparam logic [HOLD_W-1:0]   BOOT_HOLD        = HOLD_W'(100);
    localparam logic [KEY_W-1:0]    LAST_KEY         = KEY_W'(NUM_KEYS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_PERIOD  = 2'd0,
        REG_FIRST_REPEAT = 2'd1,
        REG_REPEAT       = 2'd2,
        REG_KEY_ENABLE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KS_IDLE = 2'd0,
        KS_DOWN = 2'd1,
        KS_UP   = 2'd2
    } key_state_t;

    typedef enum logic [1:0] {
        PH_NONE     = 2'd0,
        PH_RELEASED = 2'd1,
        PH_EMITTED  = 2'd2
    } phase_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic out_load;
    } kbar_cmd_t;

    typedef struct packed {
        logic scan_due;
        logic last_key;
    } kbar_status_t;

endpackage

`default_nettype wire

/* sv/key_debounce_auto_repeat.sv */
// top level of the key debounce / auto-repeat scanner
// depends on kbar_pkg, kbar_ctrl, kbar_datapath and assert_macros.svh
//
// One input transaction per 1 ms tick carries the pressed level of each key and
// always yields exactly one output transaction (press_valid, press_key). A tick
// without a scan goes from acceptance straight to the done state, where its result
// is loaded into the output register. A scan tick walks the ten keys one per cycle
// through a single 32-bit elapsed-time compare before it reaches the done state. A
// finished tick waits in the done state while the output register holds a stalled
// result, and its result is loaded once that register is free. The next tick is
// accepted as soon as the result sits in the output register, even while that
// result is stalled.
// Configuration writes are accepted in any cycle and must only be issued idle.
`default_nettype none
`include "assert_macros.svh"

module key_debounce_auto_repeat
    import kbar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [MASK_W-1:0]     pressed_mask,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       press_valid,
    output logic [3:0]                 press_key,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    kbar_cmd_t    cmd;
    kbar_status_t status;

    assign cfg_ready = 1'b1;

    kbar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kbar_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pressed_mask (pressed_mask),
        .press_valid  (press_valid),
        .press_key    (press_key)
    );

    `ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.scan_step, cmd.out_load}))
    `ASSERT_IMPL(a_key_in_range, out_valid && press_valid, press_key <= 4'(LAST_KEY))
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

/* sv/kbar_ctrl.sv */
// controller: sequences accept, key walk and result hand-off
// depends on kbar_pkg
`default_nettype none

module kbar_ctrl
    import kbar_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire kbar_status_t status,
    output kbar_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.scan_due ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.last_key)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* sv/kbar_datapath.sv */
// datapath: config registers, key states, hold times, timing and result
// depends on kbar_pkg
`default_nettype none

module kbar_datapath
    import kbar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kbar_cmd_t             cmd,
    output kbar_status_t               status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [MASK_W-1:0]     pressed_mask,
    output logic                       press_valid,
    output logic [3:0]                 press_key
);

    logic [PERIOD_W-1:0] scan_period_reg;
    logic [HOLD_W-1:0]   first_repeat_reg;
    logic [HOLD_W-1:0]   repeat_reg;
    logic [MASK_W-1:0]   key_enable_reg;

    logic [TIME_W-1:0]   tick_reg;
    logic [TIME_W-1:0]   last_emit_reg;
    logic [PERIOD_W-1:0] div_reg;
    phase_t              phase_reg;
    key_state_t          key_state_reg [NUM_KEYS];
    logic [HOLD_W-1:0]   hold_reg [NUM_KEYS];
    logic [MASK_W-1:0]   prev_reg;

    logic [MASK_W-1:0]   level_reg;
    logic [KEY_W-1:0]    idx_reg;
    logic                res_valid_reg;
    logic [KEY_W-1:0]    res_key_reg;
    logic                press_valid_reg;
    logic [3:0]          press_key_reg;

    logic [MASK_W-1:0]   level;
    logic [MASK_W-1:0]   changed;
    logic [TIME_W-1:0]   elapsed;
    logic                emit;
    logic                release_done;

    assign level   = pressed_mask & key_enable_reg;
    assign changed = (level ^ prev_reg) & key_enable_reg;
    assign elapsed = tick_reg - last_emit_reg;

    assign emit = (key_state_reg[idx_reg] == KS_DOWN) && level_reg[idx_reg]
                  && (elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_reg[idx_reg]});
    assign release_done = (key_state_reg[idx_reg] == KS_UP) && !level_reg[idx_reg];

    assign status.scan_due = (div_reg >= scan_period_reg);
    assign status.last_key = (idx_reg == LAST_KEY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg  <= SCAN_PERIOD_RST;
            first_repeat_reg <= FIRST_REPEAT_RST;
            repeat_reg       <= REPEAT_RST;
            key_enable_reg   <= KEY_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCAN_PERIOD:  scan_period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_FIRST_REPEAT: first_repeat_reg <= cfg_data[HOLD_W-1:0];
                REG_REPEAT:       repeat_reg       <= cfg_data[HOLD_W-1:0];
                REG_KEY_ENABLE:   key_enable_reg   <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            last_emit_reg <= '0;
            div_reg       <= '0;
            phase_reg     <= PH_NONE;
            prev_reg      <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_state_reg[i] <= KS_IDLE;
                hold_reg[i]      <= BOOT_HOLD;
            end
        end
        else if (cmd.accept)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                if (changed[i])
                begin
                    key_state_reg[i] <= level[i] ? KS_DOWN : KS_UP;
                end
            end
            prev_reg <= level;
            tick_reg <= tick_reg + TIME_W'(1);
            div_reg  <= status.scan_due ? '0 : div_reg + PERIOD_W'(1);
        end
        else if (cmd.scan_step)
        begin
            if (emit)
            begin
                last_emit_reg     <= tick_reg;
                hold_reg[idx_reg] <= (phase_reg == PH_RELEASED) ? first_repeat_reg
                                                                : repeat_reg;
                phase_reg         <= PH_EMITTED;
            end
            else if (release_done)
            begin
                key_state_reg[idx_reg] <= KS_IDLE;
                hold_reg[idx_reg]      <= repeat_reg;
                phase_reg              <= PH_RELEASED;
            end
        end
    end

    // per-item working registers and the output register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            level_reg     <= level;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_key_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + KEY_W'(1);
            if (emit)
            begin
                res_valid_reg <= 1'b1;
                res_key_reg   <= idx_reg;
            end
        end
        if (cmd.out_load)
        begin
            press_valid_reg <= res_valid_reg;
            press_key_reg   <= 4'(res_key_reg);
        end
    end

    assign press_valid = press_valid_reg;
    assign press_key   = press_key_reg;

endmodule

`default_nettype wire

/* tb/sv/kbar_checker.sv */
// scoreboard for the key debounce / auto-repeat scanner: tracks register writes,
// predicts one press result per accepted tick and compares the output transactions
// depends on kbar_pkg
`default_nettype none

module kbar_checker
    import kbar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [MASK_W-1:0]     pressed_mask,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  press_valid,
    input  wire logic [3:0]            press_key,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         errors,
    output int                         waiting,
    output int                         ticks,
    output int                         scans,
    output int                         events,
    output int                         writes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       valid;
        logic [3:0] key;
    } press_t;

    press_t              press_q[$];

    logic [PERIOD_W-1:0] scan_period_r;
    logic [HOLD_W-1:0]   first_repeat_r;
    logic [HOLD_W-1:0]   repeat_r;
    logic [MASK_W-1:0]   enable_r;

    logic [TIME_W-1:0]   now_ms;
    logic [TIME_W-1:0]   last_press_ms;
    logic [PERIOD_W-1:0] divider;
    phase_t              phase;
    key_state_t          kstate [NUM_KEYS];
    logic [HOLD_W-1:0]   hold [NUM_KEYS];
    logic [MASK_W-1:0]   prev_level;

    // advances the scanner by one tick and returns the press it reports
    function automatic press_t next_press(input logic [MASK_W-1:0] mask);
        logic [MASK_W-1:0] level;
        logic [MASK_W-1:0] changed;
        press_t            p;
        level   = mask & enable_r;
        changed = (level ^ prev_level) & enable_r;
        p       = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (changed[k])
                kstate[k] = level[k] ? KS_DOWN : KS_UP;
        end
        prev_level = level;
        now_ms     = now_ms + 1;
        if (divider >= scan_period_r)
        begin
            divider = '0;
            scans++;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (kstate[k] == KS_DOWN && level[k] &&
                    (now_ms - last_press_ms) > TIME_W'(hold[k]))
                begin
                    last_press_ms = now_ms;
                    p.valid       = 1'b1;
                    p.key         = 4'(k);
                    hold[k]       = (phase == PH_RELEASED) ? first_repeat_r : repeat_r;
                    phase         = PH_EMITTED;
                end
                else if (kstate[k] == KS_UP && !level[k])
                begin
                    kstate[k] = KS_IDLE;
                    hold[k]   = repeat_r;
                    phase     = PH_RELEASED;
                end
            end
        end
        else
        begin
            divider = divider + 1'b1;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        press_t want;
        if (!rst_n)
        begin
            press_q.delete();
            scan_period_r  = SCAN_PERIOD_RST;
            first_repeat_r = FIRST_REPEAT_RST;
            repeat_r       = REPEAT_RST;
            enable_r       = KEY_ENABLE_RST;
            now_ms         = '0;
            last_press_ms  = '0;
            divider        = '0;
            phase          = PH_NONE;
            prev_level     = '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                kstate[k] = KS_IDLE;
                hold[k]   = BOOT_HOLD;
            end
            errors = 0;
            ticks  = 0;
            scans  = 0;
            events = 0;
            writes = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                writes++;
                case (cfg_reg_t'(cfg_index))
                    REG_SCAN_PERIOD:  scan_period_r  = cfg_data[PERIOD_W-1:0];
                    REG_FIRST_REPEAT: first_repeat_r = cfg_data[HOLD_W-1:0];
                    REG_REPEAT:       repeat_r       = cfg_data[HOLD_W-1:0];
                    REG_KEY_ENABLE:   enable_r       = cfg_data[MASK_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                ticks++;
                want = next_press(pressed_mask);
                if (want.valid)
                    events++;
                press_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (press_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no tick pending, expected none, actual valid %0d key %0d",
                             $time, press_valid, press_key);
                end
                else
                begin
                    want = press_q.pop_front();
                    if (press_valid !== want.valid)
                    begin
                        errors++;
                        $display("%0t: press_valid mismatch, expected %0d actual %0d",
                                 $time, want.valid, press_valid);
                    end
                    if (press_key !== want.key)
                    begin
                        errors++;
                        $display("%0t: press_key mismatch, expected %0d actual %0d",
                                 $time, want.key, press_key);
                    end
                end
            end
        end
        waiting = press_q.size();
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench top for key_debounce_auto_repeat: clock, reset, tick and register
// stimulus, receiver stalls, watchdog and verdict
// depends on kbar_pkg, kbar_checker and the scanner rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kbar_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 103;
    localparam int HOLD_OFF    = 240;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic [MASK_W-1:0]     pressed_mask = '0;
    logic                  out_stall    = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    wire logic             in_stall;
    wire logic             out_valid;
    wire logic             press_valid;
    wire logic [3:0]       press_key;
    wire logic             cfg_ready;

    bit                    steady       = 1'b0;
    int                    hold_reqs    = 0;

    int                    errors;
    int                    waiting;
    int                    ticks;
    int                    scans;
    int                    events;
    int                    writes;

    key_debounce_auto_repeat u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pressed_mask (pressed_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .press_valid  (press_valid),
        .press_key    (press_key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    kbar_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pressed_mask (pressed_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .press_valid  (press_valid),
        .press_key    (press_key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .waiting      (waiting),
        .ticks        (ticks),
        .scans        (scans),
        .events       (events),
        .writes       (writes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // offers one tick transaction, called and returning at a falling edge
    task automatic send_tick(input logic [MASK_W-1:0] mask);
        while (!steady && $urandom_range(99) < 22)
        begin
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pressed_mask <= mask;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [PERIOD_W-1:0] sp, input logic [HOLD_W-1:0] fr,
                             input logic [HOLD_W-1:0] rp, input logic [MASK_W-1:0] en);
        write_reg(REG_SCAN_PERIOD, CFG_DATA_W'(sp));
        write_reg(REG_FIRST_REPEAT, CFG_DATA_W'(fr));
        write_reg(REG_REPEAT, CFG_DATA_W'(rp));
        write_reg(REG_KEY_ENABLE, CFG_DATA_W'(en));
        cfg_valid <= 1'b0;
    endtask

    // sender pause until every pending result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        wait (waiting == 0);
        repeat (3) @(negedge clk);
    endtask

    function automatic logic [HOLD_W-1:0] pick_hold(input int max_ms);
        int r;
        r = $urandom_range(5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return HOLD_W'($urandom_range(max_ms, 1));
    endfunction

    initial
    begin : receiver
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (served != hold_reqs)
            begin
                served    = hold_reqs;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady && $urandom_range(99) < 22;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("key_debounce_auto_repeat regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [MASK_W-1:0]   held;
        logic [PERIOD_W-1:0] sp;
        logic [MASK_W-1:0]   en;
        held = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, keys 0, 4, 8 and 9 not enabled
        send_tick(10'h000);
        send_tick(10'h3FF);
        send_tick(10'h001);
        send_tick(10'h200);
        drain();

        // scan every tick, short holds: release marks, lowest key wins, repeats
        configure(8'd0, 16'd2, 16'd1, 10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h000);
        send_tick(10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h2AA);
        send_tick(10'h2AA);
        send_tick(10'h155);
        send_tick(10'h000);
        drain();

        // zero holds, partial enable
        configure(8'd0, 16'd0, 16'd0, 10'h0F0);
        send_tick(10'h3FF);
        send_tick(10'h00F);
        send_tick(10'h0F0);
        send_tick(10'h000);
        send_tick(10'h3FF);
        drain();

        // widest period and holds, then a lowered period scans at once
        configure(8'd255, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h000);
        send_tick(10'h3FF);
        drain();
        configure(8'd1, 16'd3, 16'd2, 10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h3FF);
        send_tick(10'h000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            sp = (p == 2) ? 8'd255 : PERIOD_W'($urandom_range(3));
            en = (p == 0) ? 10'h3FF : (p == 6) ? 10'h000 : MASK_W'($urandom_range(1023));
            configure(sp, pick_hold(30), pick_hold(20), en);
            steady <= (p == 3);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (p == 1 && n == 40)
                    hold_reqs <= hold_reqs + 1;
                for (int k = 0; k < MASK_W; k++)
                begin
                    if ($urandom_range(11) == 0)
                        held[k] = ~held[k];
                end
                if ($urandom_range(99) < 12)
                    send_tick(MASK_W'($urandom_range(1023)));
                else
                    send_tick(held);
            end
            drain();
        end

        repeat (20) @(negedge clk);
        $display("covered %0d ticks, %0d scans, %0d press events, %0d register writes",
                 ticks, scans, events, writes);
        if (errors == 0 && waiting == 0)
            $display("key_debounce_auto_repeat regression: pass");
        else
            $display("key_debounce_auto_repeat regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
